// ===== design/nmea_rmc_time_date_extractor_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_TIME_DATE_EXTRACTOR_DEFINES_SVH
`define NMEA_RMC_TIME_DATE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication.
`define NRMC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrmc same-cycle check failed");

// Next-cycle implication.
`define NRMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrmc next-cycle check failed");

`endif

// ===== design/nrmc_pkg.sv =====
// ----------------------------------------------------------------------------
// nrmc_pkg
// Constants, types and helpers shared by the NMEA RMC time/date extractor.
// ----------------------------------------------------------------------------
package nrmc_pkg;

	localparam int MAX_LINE    = 256;
	localparam int POS_W       = $clog2(MAX_LINE + 1);
	localparam int PREFIX_LEN  = 6;
	localparam int TIME_FIRST  = 7;
	localparam int TIME_LAST   = 12;
	localparam int TIME_NEEDED = 13;
	localparam int DATE_COMMA  = 9;
	localparam int FIELD_CHARS = 6;
	localparam int IDX_W       = $clog2(FIELD_CHARS + 1);

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	typedef logic [FIELD_CHARS-1:0][7:0] chars_t;

	// Line state seen by the decoder when a newline arrives
	typedef struct packed {
		logic   matched;
		logic   time_full;
		logic   date_found;
		chars_t time_chars;
		chars_t date_chars;
	} snap_t;

	// One result transaction
	typedef struct packed {
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
		logic [6:0] day;
		logic [6:0] month;
		logic [6:0] year;
		logic       date_found;
		logic       format_error;
	} res_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h4E; // N
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	// Two ASCII digits to 0..99
	function automatic logic [6:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
		return 7'(7'(hi[3:0]) * 7'd10 + 7'(lo[3:0]));
	endfunction

endpackage

// ===== design/nmea_rmc_time_date_extractor.sv =====
// After its newline byte is accepted, a result passes through the input
// register, then the result register.
// Throughput: one byte per cycle while results are taken; a stalled result
// holds the byte in the input register, so the input stalls until it is taken.
// Reset clears the line state (position, prefix flag, comma and date counts)
// and both valid flags; the capture buffers are not reset.
// ----------------------------------------------------------------------------
// nmea_rmc_time_date_extractor
// Extracts UTC time and date from $GNRMC lines in a received byte stream.
// ----------------------------------------------------------------------------
module nmea_rmc_time_date_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] hours,
	output logic [6:0] minutes,
	output logic [6:0] seconds,
	output logic [6:0] day,
	output logic [6:0] month,
	output logic [6:0] year,
	output logic       date_found,
	output logic       format_error
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            out_valid_s2;
	nrmc_pkg::res_t  res_s2;

	logic            advance;
	logic            step;
	nrmc_pkg::snap_t snap;
	nrmc_pkg::res_t  res;

	assign advance  = !(out_valid_s2 && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	// Input register; drop bytes of 128 and above here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && !rx_byte[7];
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	nrmc_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.char_in (byte_s1),
		.snap    (snap)
	);

	nrmc_decode u_decode (
		.snap (snap),
		.res  (res)
	);

	// Result register; hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= step && (byte_s1 == nrmc_pkg::CHAR_NEWLINE) && snap.matched;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = out_valid_s2;
	assign hours        = res_s2.hours;
	assign minutes      = res_s2.minutes;
	assign seconds      = res_s2.seconds;
	assign day          = res_s2.day;
	assign month        = res_s2.month;
	assign year         = res_s2.year;
	assign date_found   = res_s2.date_found;
	assign format_error = res_s2.format_error;

endmodule

// ===== design/nrmc_capture.sv =====
// ----------------------------------------------------------------------------
// nrmc_capture
// Line tracker: position, prefix check, comma count and character capture.
// ----------------------------------------------------------------------------
module nrmc_capture (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          char_in,
	output nrmc_pkg::snap_t     snap
);

	logic [nrmc_pkg::POS_W-1:0] pos_q;
	logic                       prefix_q;
	logic [3:0]                 comma_q;
	logic [nrmc_pkg::IDX_W-1:0] taken_q;
	nrmc_pkg::chars_t           time_q;
	nrmc_pkg::chars_t           date_q;

	logic is_nl;
	logic room;
	logic in_prefix;
	logic in_time;
	logic take_date;

	assign is_nl     = (char_in == nrmc_pkg::CHAR_NEWLINE);
	assign room      = (pos_q < nrmc_pkg::POS_W'(nrmc_pkg::MAX_LINE));
	assign in_prefix = (pos_q < nrmc_pkg::POS_W'(nrmc_pkg::PREFIX_LEN));
	assign in_time   = (pos_q >= nrmc_pkg::POS_W'(nrmc_pkg::TIME_FIRST)) &&
	                   (pos_q <= nrmc_pkg::POS_W'(nrmc_pkg::TIME_LAST));
	assign take_date = (comma_q == 4'(nrmc_pkg::DATE_COMMA)) &&
	                   (taken_q < nrmc_pkg::IDX_W'(nrmc_pkg::FIELD_CHARS));

	// Advance line state; clear it on newline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prefix_q <= 1'b1;
			comma_q  <= '0;
			taken_q  <= '0;
		end else if (step) begin
			if (is_nl) begin
				pos_q    <= '0;
				prefix_q <= 1'b1;
				comma_q  <= '0;
				taken_q  <= '0;
			end else if (room) begin
				pos_q <= pos_q + 1'b1;
				if (in_prefix && (char_in != nrmc_pkg::prefix_char(pos_q[2:0]))) begin
					prefix_q <= 1'b0;
				end
				if (take_date) begin
					taken_q <= taken_q + 1'b1;
				end
				if ((char_in == nrmc_pkg::CHAR_COMMA) &&
				    (comma_q < 4'(nrmc_pkg::DATE_COMMA))) begin
					comma_q <= comma_q + 1'b1;
				end
			end
		end
	end

	// Capture time and date characters
	always_ff @(posedge clk) begin
		if (step && !is_nl && room) begin
			if (in_time) begin
				time_q[3'(pos_q - nrmc_pkg::POS_W'(nrmc_pkg::TIME_FIRST))] <= char_in;
			end
			if (take_date) begin
				date_q[taken_q] <= char_in;
			end
		end
	end

	// Present line state to the decoder
	assign snap.matched    = prefix_q && !in_prefix;
	assign snap.time_full  = (pos_q >= nrmc_pkg::POS_W'(nrmc_pkg::TIME_NEEDED));
	assign snap.date_found = (taken_q >= nrmc_pkg::IDX_W'(nrmc_pkg::FIELD_CHARS));
	assign snap.time_chars = time_q;
	assign snap.date_chars = date_q;

endmodule

// ===== design/nrmc_decode.sv =====
// ----------------------------------------------------------------------------
// nrmc_decode
// Digit check and pair conversion of the captured time and date.
// ----------------------------------------------------------------------------
module nrmc_decode (
	input  nrmc_pkg::snap_t snap,
	output nrmc_pkg::res_t  res
);

	logic time_digits;
	logic date_digits;
	logic time_ok;
	logic date_ok;

	// Check every captured character for a digit
	always_comb begin
		time_digits = 1'b1;
		date_digits = 1'b1;
		for (int i = 0; i < nrmc_pkg::FIELD_CHARS; i++) begin
			time_digits = time_digits & nrmc_pkg::is_digit(snap.time_chars[i]);
			date_digits = date_digits & nrmc_pkg::is_digit(snap.date_chars[i]);
		end
	end

	assign time_ok = snap.time_full && time_digits;
	assign date_ok = snap.date_found && date_digits;

	// Convert pairs; zero the fields that failed
	always_comb begin
		res = '0;
		if (time_ok) begin
			res.hours   = nrmc_pkg::pair_value(snap.time_chars[0], snap.time_chars[1]);
			res.minutes = nrmc_pkg::pair_value(snap.time_chars[2], snap.time_chars[3]);
			res.seconds = nrmc_pkg::pair_value(snap.time_chars[4], snap.time_chars[5]);
		end
		if (date_ok) begin
			res.day   = nrmc_pkg::pair_value(snap.date_chars[0], snap.date_chars[1]);
			res.month = nrmc_pkg::pair_value(snap.date_chars[2], snap.date_chars[3]);
			res.year  = nrmc_pkg::pair_value(snap.date_chars[4], snap.date_chars[5]);
		end
		res.date_found   = snap.date_found;
		res.format_error = !time_ok || (snap.date_found && !date_ok);
	end

endmodule

// ===== design/nrmc_checker.sv =====
// ----------------------------------------------------------------------------
// nrmc_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "nmea_rmc_time_date_extractor_defines.svh"

module nrmc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [6:0] hours,
	input logic [6:0] minutes,
	input logic [6:0] seconds,
	input logic [6:0] day,
	input logic [6:0] month,
	input logic [6:0] year,
	input logic       date_found,
	input logic       format_error
);

	logic [43:0] res_bits;
	logic        date_zero;
	logic        pairs_ok;

	// Gather the result fields for the checks below
	assign res_bits  = {hours, minutes, seconds, day, month, year, date_found, format_error};
	assign date_zero = (day == 7'd0) && (month == 7'd0) && (year == 7'd0);
	assign pairs_ok  = (hours < 7'd100) && (minutes < 7'd100) && (seconds < 7'd100) &&
	                   (day < 7'd100) && (month < 7'd100) && (year < 7'd100);

	// A stalled result transaction holds
	`NRMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_bits))

	// A missing date reads as zero
	`NRMC_ASSERT_IMPL(a_no_date_zero, out_valid && !date_found, date_zero)

	// Decoded pairs never exceed 99
	`NRMC_ASSERT_IMPL(a_pair_range, out_valid, pairs_ok)

	// An empty result register never stalls the input
	`NRMC_ASSERT_IMPL(a_input_free, !out_valid, !in_stall)

endmodule

bind nmea_rmc_time_date_extractor nrmc_checker u_nrmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.hours        (hours),
	.minutes      (minutes),
	.seconds      (seconds),
	.day          (day),
	.month        (month),
	.year         (year),
	.date_found   (date_found),
	.format_error (format_error)
);

// ===== tb/tb_nmea_rmc_time_date_extractor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nmea_rmc_time_date_extractor
// Self-checking bench for the RMC time/date extractor. A byte-level line
// tracker inside a small scoreboard predicts one fix per $GNRMC line. Every
// result transaction is checked field by field against the oldest prediction.
// Stimulus is a directed set of sentences followed by random sentences,
// mostly well formed, some broken, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_time_date_extractor;

	localparam int WATCHDOG_CYCLES = 1000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_CHARS    = 900;
	localparam int MIN_FIXES       = 32;
	localparam int REPORT_LIMIT    = 10;

	localparam logic [47:0] RMC_TAG         = "$GNRMC";
	localparam logic [7:0]  HIGH_BYTE_FIRST = 8'd128;
	localparam logic [7:0]  CHAR_DOT        = 8'h2E;
	localparam logic [7:0]  CHAR_RETURN     = 8'h0D;
	localparam logic [7:0]  CHAR_STAR       = 8'h2A;
	localparam logic [7:0]  CHAR_PAD        = 8'h41;

	// Line tracker and store of predicted fixes
	class rmc_fix_book;
		int unsigned      line_len;
		bit               tag_ok;
		int unsigned      commas;
		int unsigned      date_taken;
		logic [5:0][7:0]  time_buf;
		logic [5:0][7:0]  date_buf;
		nrmc_pkg::res_t   pending_fixes[$];
		int unsigned      predicted;
		int unsigned      checked;
		int unsigned      dated;
		int unsigned      flagged;
		int unsigned      errors;

		function new();
			time_buf = '0;
			date_buf = '0;
			predicted = 0;
			checked = 0;
			dated = 0;
			flagged = 0;
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			line_len = 0;
			tag_ok = 1'b1;
			commas = 0;
			date_taken = 0;
		endfunction

		function bit numeric(logic [7:0] c);
			return c >= nrmc_pkg::CHAR_ZERO && c <= nrmc_pkg::CHAR_NINE;
		endfunction

		function bit all_numeric(logic [5:0][7:0] s);
			for (int i = 0; i < nrmc_pkg::FIELD_CHARS; i++) begin
				if (!numeric(s[i]))
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function logic [6:0] decimal_pair(logic [7:0] hi, logic [7:0] lo);
			int unsigned v;
			v = 10 * (hi - nrmc_pkg::CHAR_ZERO) + (lo - nrmc_pkg::CHAR_ZERO);
			return v[6:0];
		endfunction

		// Advance the line state by one accepted byte; predict a fix on newline
		function void take_byte(logic [7:0] b);
			nrmc_pkg::res_t fix;
			bit   time_ok;
			bit   found;
			bit   date_ok;
			if (b >= HIGH_BYTE_FIRST)
				return;
			if (b == nrmc_pkg::CHAR_NEWLINE) begin
				if (tag_ok && line_len >= nrmc_pkg::PREFIX_LEN) begin
					time_ok = line_len >= nrmc_pkg::TIME_NEEDED && all_numeric(time_buf);
					found = date_taken >= nrmc_pkg::FIELD_CHARS;
					date_ok = found && all_numeric(date_buf);
					fix = '0;
					if (time_ok) begin
						fix.hours   = decimal_pair(time_buf[0], time_buf[1]);
						fix.minutes = decimal_pair(time_buf[2], time_buf[3]);
						fix.seconds = decimal_pair(time_buf[4], time_buf[5]);
					end
					if (date_ok) begin
						fix.day   = decimal_pair(date_buf[0], date_buf[1]);
						fix.month = decimal_pair(date_buf[2], date_buf[3]);
						fix.year  = decimal_pair(date_buf[4], date_buf[5]);
					end
					fix.date_found = found;
					fix.format_error = !time_ok || (found && !date_ok);
					pending_fixes.push_back(fix);
					predicted++;
				end
				clear_line();
				return;
			end
			// Drop characters past the end of the line buffer
			if (line_len >= nrmc_pkg::MAX_LINE)
				return;
			if (line_len < nrmc_pkg::PREFIX_LEN) begin
				if (b != RMC_TAG[47 - 8 * line_len -: 8])
					tag_ok = 1'b0;
			end else if (line_len >= nrmc_pkg::TIME_FIRST &&
				line_len <= nrmc_pkg::TIME_LAST) begin
				time_buf[line_len - nrmc_pkg::TIME_FIRST] = b;
			end
			if (commas == nrmc_pkg::DATE_COMMA && date_taken < nrmc_pkg::FIELD_CHARS) begin
				date_buf[date_taken] = b;
				date_taken++;
			end
			if (b == nrmc_pkg::CHAR_COMMA && commas < nrmc_pkg::DATE_COMMA)
				commas++;
			line_len++;
		endfunction

		function void report(string what, nrmc_pkg::res_t want, nrmc_pkg::res_t got);
			errors++;
			if (errors <= REPORT_LIMIT) begin
				$display("%0t ns: %s: want %0d:%0d:%0d %0d/%0d/%0d found=%0b err=%0b",
					$realtime, what,
					want.hours, want.minutes, want.seconds, want.day, want.month, want.year,
					want.date_found, want.format_error);
				$display("    got %0d:%0d:%0d %0d/%0d/%0d found=%0b err=%0b",
					got.hours, got.minutes, got.seconds, got.day, got.month, got.year,
					got.date_found, got.format_error);
			end
		endfunction

		// Compare one result transaction with the oldest predicted fix
		function void match_fix(nrmc_pkg::res_t got);
			nrmc_pkg::res_t want;
			if (pending_fixes.size() == 0) begin
				report("result with nothing pending", '0, got);
				return;
			end
			want = pending_fixes.pop_front();
			checked++;
			if (want.date_found)
				dated++;
			if (want.format_error)
				flagged++;
			if (got.hours !== want.hours || got.minutes !== want.minutes ||
				got.seconds !== want.seconds || got.day !== want.day ||
				got.month !== want.month || got.year !== want.year ||
				got.date_found !== want.date_found ||
				got.format_error !== want.format_error)
				report("fix mismatch", want, got);
		endfunction
	endclass

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [6:0] hours;
	logic [6:0] minutes;
	logic [6:0] seconds;
	logic [6:0] day;
	logic [6:0] month;
	logic [6:0] year;
	logic       date_found;
	logic       format_error;

	rmc_fix_book book = new();
	logic [7:0]  line_q[$];
	bit          sprinkle_high;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int unsigned accepted_chars = 0;
	int unsigned skipped_high = 0;
	int unsigned lines_ended = 0;
	int unsigned quiet_cycles = 0;

	nmea_rmc_time_date_extractor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hours        (hours),
		.minutes      (minutes),
		.seconds      (seconds),
		.day          (day),
		.month        (month),
		.year         (year),
		.date_found   (date_found),
		.format_error (format_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Monitor both channels and track progress for the watchdog
	always @(posedge clk) begin
		if (in_valid === 1'b1 && in_stall === 1'b0) begin
			book.take_byte(rx_byte);
			if (rx_byte >= HIGH_BYTE_FIRST)
				skipped_high++;
			else
				accepted_chars++;
			if (rx_byte == nrmc_pkg::CHAR_NEWLINE)
				lines_ended++;
		end
		if (out_valid === 1'b1 && out_stall === 1'b0)
			book.match_fix({hours, minutes, seconds, day, month, year, date_found, format_error});
		if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// End a run that has stopped moving
	initial begin
		wait (quiet_cycles >= WATCHDOG_CYCLES);
		$display("nmea_rmc_time_date_extractor regression: fail");
		$finish;
	end

	function automatic logic [7:0] any_printable();
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] digit_char();
		return nrmc_pkg::CHAR_ZERO + 8'($urandom_range(9));
	endfunction

	// Mostly digits, with the odd stray character
	function automatic logic [7:0] pair_char();
		return ($urandom_range(99) < 3) ? any_printable() : digit_char();
	endfunction

	function automatic logic [7:0] field_char();
		logic [7:0] c;
		c = any_printable();
		return (c == nrmc_pkg::CHAR_COMMA) ? CHAR_DOT : c;
	endfunction

	// Queue one byte, now and then behind a byte the block must skip
	function automatic void put(logic [7:0] b);
		if (sprinkle_high && $urandom_range(99) < 4)
			line_q.push_back(8'($urandom_range(128, 255)));
		line_q.push_back(b);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic string rmc_text(string hhmmss, string date_tail);
		return {"$GNRMC,", hhmmss, ",A,,,,,,,", date_tail, "\n"};
	endfunction

	// Drive one transaction, idling first when the dice say so
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic send_line();
		while (line_q.size() != 0)
			send_byte(line_q.pop_front());
	endtask

	// Hold the sender until every predicted fix has come out
	task automatic drain_fixes();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending_fixes.size() != 0)
			@(posedge clk);
	endtask

	// RMC sentence with random content; bad_at corrupts one tag character
	task automatic rmc_random(input int bad_at, input int field_commas);
		int         i;
		int         date_len;
		logic [7:0] c;
		for (i = 0; i < nrmc_pkg::PREFIX_LEN; i++) begin
			c = RMC_TAG[47 - 8 * i -: 8];
			if (i == bad_at)
				c = any_printable();
			put(c);
		end
		put(nrmc_pkg::CHAR_COMMA);
		repeat (nrmc_pkg::FIELD_CHARS) put(pair_char());
		if ($urandom_range(1)) begin
			put(CHAR_DOT);
			put(digit_char());
			put(digit_char());
		end
		repeat (field_commas) begin
			repeat ($urandom_range(3)) put(field_char());
			put(nrmc_pkg::CHAR_COMMA);
		end
		date_len = ($urandom_range(9) == 0) ? $urandom_range(5) : nrmc_pkg::FIELD_CHARS;
		repeat (date_len) put(pair_char());
		if (date_len == nrmc_pkg::FIELD_CHARS) begin
			repeat ($urandom_range(3)) begin
				put(nrmc_pkg::CHAR_COMMA);
				repeat ($urandom_range(2)) put(field_char());
			end
			put(CHAR_STAR);
			put(digit_char());
			put(digit_char());
			put(CHAR_RETURN);
		end
		put(nrmc_pkg::CHAR_NEWLINE);
	endtask

	// Pick a line shape: mostly good sentences, the rest broken or noise
	task automatic random_line();
		int kind;
		int cut;
		int i;
		kind = $urandom_range(99);
		if (kind < 72) begin
			rmc_random(-1, nrmc_pkg::DATE_COMMA - 1);
		end else if (kind < 78) begin
			rmc_random(-1, $urandom_range(nrmc_pkg::DATE_COMMA - 2));
		end else if (kind < 85) begin
			rmc_random($urandom_range(nrmc_pkg::PREFIX_LEN - 1), nrmc_pkg::DATE_COMMA - 1);
		end else if (kind < 92) begin
			cut = $urandom_range(nrmc_pkg::TIME_LAST);
			for (i = 0; i < cut; i++) begin
				if (i < nrmc_pkg::PREFIX_LEN)
					put(RMC_TAG[47 - 8 * i -: 8]);
				else
					put((i == nrmc_pkg::PREFIX_LEN) ? nrmc_pkg::CHAR_COMMA : digit_char());
			end
			put(nrmc_pkg::CHAR_NEWLINE);
		end else if (kind < 98) begin
			repeat ($urandom_range(20)) put(8'($urandom_range(127)));
			put(nrmc_pkg::CHAR_NEWLINE);
		end else begin
			put_text("$GNRMC,");
			repeat (nrmc_pkg::FIELD_CHARS) put(digit_char());
			repeat (nrmc_pkg::MAX_LINE + $urandom_range(40))
				put(($urandom_range(9) == 0) ? nrmc_pkg::CHAR_COMMA : field_char());
			put(nrmc_pkg::CHAR_NEWLINE);
		end
		send_line();
	endtask

	// Directed sentences: extremes, each error path, skipped bytes, overlong lines
	task automatic directed_lines();
		sprinkle_high = 1'b0;
		put_text(rmc_text("000000.00", "010100,,,A*6C"));
		put_text(rmc_text("999999", "999999"));
		put_text(rmc_text("235959.00", "311299,003.1,W*6A"));
		put_text(rmc_text("12a456", "150624"));
		put_text(rmc_text("010203", "1x0624"));
		put_text(rmc_text("010203", "15,624"));
		put_text(rmc_text("010203", "1506"));
		put_text(rmc_text("123456", "150624,,,,"));
		put_text(rmc_text("123456", ""));
		put_text("$GNRMC,123456,A,1,2\n");
		put_text("$GNRMC,123456\n");
		put_text("$GNRMC,12345\n");
		put_text("$GNRMC\n");
		put_text("$GNRM\n");
		put_text("$GPRMC,123456,A,,,,,,,150624\n");
		put_text("\n");
		// High bytes, a high-bit newline among them, are skipped
		put_text("$GNR");
		put(8'hFF);
		put_text("MC,0");
		put(8'h80);
		put_text("80910,A,,,,,,,2");
		put(8'h8A);
		put_text("80299\n");
		// Date beyond the line buffer is dropped
		put_text("$GNRMC,112233");
		repeat (nrmc_pkg::MAX_LINE) put(CHAR_PAD);
		put_text(",,,,,,,,010203\n");
		// Date straddles the end of the line buffer
		put_text("$GNRMC,112233,");
		repeat (nrmc_pkg::MAX_LINE - 24) put(CHAR_PAD);
		put_text(",,,,,,,010203\n");
		send_line();
		sprinkle_high = 1'b1;
	endtask

	initial begin
		int unsigned random_base;
		int          phase;
		int unsigned failures;
		tx_idle_pct = 16;
		rx_idle_pct = 61;
		sprinkle_high = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_lines();
		drain_fixes();
		random_base = accepted_chars;

		// Three idling phases: sender light, receiver light, none
		for (phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				tx_idle_pct = 61;
				rx_idle_pct = 16;
			end else if (phase == 2) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			while (accepted_chars - random_base < RANDOM_CHARS * (phase + 1) / 3 ||
				(phase == 2 && book.predicted < MIN_FIXES))
				random_line();
			drain_fixes();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		failures = book.errors + book.pending_fixes.size();
		$display("Covered %0d line bytes (%0d high bytes skipped) over %0d lines.",
			accepted_chars, skipped_high, lines_ended);
		$display("Checked %0d fixes: %0d with a date, %0d flagged as malformed, %0d failures.",
			book.checked, book.dated, book.flagged, failures);
		if (failures == 0)
			$display("nmea_rmc_time_date_extractor regression: pass");
		else
			$display("nmea_rmc_time_date_extractor regression: fail");
		$finish;
	end

endmodule
